// File: hdl/sha256c_pkg.sv
// ============================================================================
// SHA-256 compression package
// Shared types, round constants and the SHA-256 bit functions.
// ============================================================================
package sha256c_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CHAIN_WORDS = 8;
    localparam int unsigned SCHED_WORDS = 16;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned BLOCK_WORDS = CHAIN_WORDS + SCHED_WORDS;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } state_t;

    // schedule control from the sequencer
    typedef struct packed {
        logic load;
        logic step;
    } sched_ctrl_t;

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t byte_rev(input word_t x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

// File: hdl/sha256c_sched.sv
// ============================================================================
// SHA-256 message schedule
// Sixteen-word sliding window: loads byte-reversed message words, then
// produces one schedule word per round at the head of the window.
// ============================================================================
module sha256c_sched
    import sha256c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sched_ctrl_t ctrl,
    input  word_t       load_word,
    output word_t       w_cur
);

    // win_reg[0] holds W[t] for the current round t
    word_t win_reg  [SCHED_WORDS];
    word_t win_next [SCHED_WORDS];
    word_t w_new;

    // W[t+16] = s1(W[t+14]) + W[t+9] + s0(W[t+1]) + W[t]
    assign w_new = small_sigma1(win_reg[14]) + win_reg[9]
                 + small_sigma0(win_reg[1]) + win_reg[0];

    always_comb
    begin
        for (int i = 0; i < SCHED_WORDS - 1; i++)
        begin
            win_next[i] = win_reg[i+1];
        end
        win_next[SCHED_WORDS-1] = ctrl.load ? byte_rev(load_word) : w_new;
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.load || ctrl.step)
        begin
            for (int i = 0; i < SCHED_WORDS; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    assign w_cur = win_reg[0];

    // window words are unknown until loaded, so compare with case equality
    a_no_load_and_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.load && ctrl.step))
        else $error("schedule loaded and stepped in the same cycle");

    a_window_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load || ctrl.step) |=> (win_reg[0] === $past(win_reg[1])))
        else $error("schedule window did not advance");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctrl.load && !ctrl.step) |=> (win_reg[0] === $past(win_reg[0])))
        else $error("schedule head changed while idle");

endmodule

// File: hdl/sha256_compression.sv
// ============================================================================
// SHA-256 compression
// One 512-bit block per 24 input words; emits the 8-word updated chain.
// ============================================================================
// Send 24 words per block on the s_ stream: the 8 chaining words a..h,
// then the 16 message words exactly as read from memory (the block
// byte-reverses each one into big-endian order). The block takes one word
// per cycle while loading, then drops s_tready and runs the 64 rounds, one
// round per cycle through a single round adder chain and the 16-word
// schedule window; the ST_FINAL state adds the input chain to the working
// variables. It then offers the 8 result words a..h on the m_ stream,
// word_index 0..7, with tlast on word h, and takes the next block only once
// word h has been taken. The new chain is not kept: supply the chaining
// words again with every block, the SHA-256 or SHA-224 initial value for
// the first one. Padding and length are up to the caller.
module sha256_compression
    import sha256c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] data_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] digest_word, [34:32] word_index
    output logic        m_tlast     // last_word
);

    localparam int unsigned LCNT_W = $clog2(BLOCK_WORDS);
    localparam int unsigned RCNT_W = $clog2(ROUNDS);
    localparam int unsigned OCNT_W = $clog2(CHAIN_WORDS);
    localparam int unsigned PAD_W  = 40 - WORD_W - OCNT_W;

    state_t              state_reg, state_next;
    logic [LCNT_W-1:0]   load_cnt_reg, load_cnt_next;
    logic [RCNT_W-1:0]   rnd_cnt_reg, rnd_cnt_next;
    logic [OCNT_W-1:0]   out_cnt_reg, out_cnt_next;

    word_t chain_reg [CHAIN_WORDS];
    word_t chain_next[CHAIN_WORDS];
    word_t vars_reg  [CHAIN_WORDS];
    word_t vars_next [CHAIN_WORDS];

    sched_ctrl_t sched_ctrl;
    word_t       w_cur;
    word_t       t1, t2;

    logic in_fire, out_fire;
    logic load_last, round_last, out_last, load_chain;

    assign in_fire    = s_tvalid && s_tready;
    assign out_fire   = m_tvalid && m_tready;
    assign load_last  = (load_cnt_reg == LCNT_W'(BLOCK_WORDS - 1));
    assign load_chain = (load_cnt_reg < LCNT_W'(CHAIN_WORDS));
    assign round_last = (rnd_cnt_reg == RCNT_W'(ROUNDS - 1));
    assign out_last   = (out_cnt_reg == OCNT_W'(CHAIN_WORDS - 1));

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && load_last)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_last)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_fire && out_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;
        sched_ctrl.load = 1'b0;
        sched_ctrl.step = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready        = 1'b1;
                sched_ctrl.load = s_tvalid && !load_chain;
            end
            ST_ROUND:
            begin
                sched_ctrl.step = 1'b1;
            end
            ST_FINAL:
            begin
                s_tready = 1'b0;
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // counters
    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        rnd_cnt_next  = rnd_cnt_reg;
        out_cnt_next  = out_cnt_reg;
        if (in_fire)
        begin
            load_cnt_next = load_last ? '0 : load_cnt_reg + 1'b1;
        end
        if (state_reg == ST_ROUND)
        begin
            rnd_cnt_next = rnd_cnt_reg + 1'b1;
        end
        if (out_fire)
        begin
            out_cnt_next = out_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            rnd_cnt_reg  <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            rnd_cnt_reg  <= rnd_cnt_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    // ---------------------------------------------------------------- schedule
    sha256c_sched u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (sched_ctrl),
        .load_word (s_tdata),
        .w_cur     (w_cur)
    );

    // ---------------------------------------------------------------- round unit
    assign t1 = vars_reg[7] + big_sigma1(vars_reg[4])
              + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
              + ROUND_K[rnd_cnt_reg] + w_cur;
    assign t2 = big_sigma0(vars_reg[0])
              + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                 ^ (vars_reg[1] & vars_reg[2]));

    always_comb
    begin
        for (int i = 0; i < CHAIN_WORDS; i++)
        begin
            chain_next[i] = chain_reg[i];
            vars_next[i]  = vars_reg[i];
        end
        priority if (in_fire && load_chain)
        begin
            // shift chaining words in from the top, word a ends at slot 0
            for (int i = 0; i < CHAIN_WORDS - 1; i++)
            begin
                chain_next[i] = chain_reg[i+1];
            end
            chain_next[CHAIN_WORDS-1] = s_tdata;
        end
        else if (in_fire && load_last)
        begin
            for (int i = 0; i < CHAIN_WORDS; i++)
            begin
                vars_next[i] = chain_reg[i];
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            vars_next[0] = t1 + t2;
            for (int i = 1; i < CHAIN_WORDS; i++)
            begin
                vars_next[i] = vars_reg[i-1];
            end
            vars_next[4] = vars_reg[3] + t1;
        end
        else if (state_reg == ST_FINAL)
        begin
            // feed-forward add
            for (int i = 0; i < CHAIN_WORDS; i++)
            begin
                chain_next[i] = chain_reg[i] + vars_reg[i];
            end
        end
        else if (out_fire)
        begin
            // advance the result words toward slot 0
            for (int i = 0; i < CHAIN_WORDS - 1; i++)
            begin
                chain_next[i] = chain_reg[i+1];
            end
        end
        else
        begin
            // hold chain and working variables
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CHAIN_WORDS; i++)
        begin
            chain_reg[i] <= chain_next[i];
            vars_reg[i]  <= vars_next[i];
        end
    end

    // ---------------------------------------------------------------- output
    assign m_tdata = {{PAD_W{1'b0}}, out_cnt_reg, chain_reg[0]};
    assign m_tlast = m_tvalid && out_last;

    // ---------------------------------------------------------------- checks
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output open at the same time");

    a_load_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (load_cnt_reg == '0))
        else $error("load count not cleared outside loading");

    a_rounds_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL) |-> (rnd_cnt_reg == '0) && $past(round_last))
        else $error("feed-forward without a full round sequence");

    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (out_cnt_reg == '0))
        else $error("result burst does not start at word a");

    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block did not return to loading after word h");

endmodule

// File: tb/sv/sha256_digest_sb_pkg.sv
`timescale 1ns / 100ps
// ============================================================================
// SHA-256 digest scoreboard
// Independent compression model and in-order store of expected digest words.
// ============================================================================
package sha256_digest_sb_pkg;

    import sha256c_pkg::word_t;

    typedef struct packed {
        word_t      digest;
        logic [2:0] index;
        logic       last;
    } digest_entry_t;

    localparam word_t SHA_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic word_t ror32(input word_t x, input int unsigned n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    function automatic word_t sum0(input word_t x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic word_t sum1(input word_t x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic word_t mix0(input word_t x);
        return ror32(x, 7) ^ ror32(x, 18) ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t mix1(input word_t x);
        return ror32(x, 17) ^ ror32(x, 19) ^ {10'b0, x[31:10]};
    endfunction

    class digest_scoreboard;

        word_t         chain_words [8];
        word_t         msg_words   [16];
        int            words_loaded;
        word_t         chain_out   [8];
        digest_entry_t pending_digest[$];
        int            mismatches;

        function new();
            words_loaded = 0;
            mismatches   = 0;
            foreach (chain_words[i]) chain_words[i] = '0;
            foreach (msg_words[i]) msg_words[i] = '0;
            foreach (chain_out[i]) chain_out[i] = '0;
        endfunction

        function int pending();
            return pending_digest.size();
        endfunction

        // 64 rounds over the collected block, schedule expanded up front
        function void compress_block();
            word_t         w [64];
            word_t         a, b, c, d, e, f, g, h, t1, t2;
            digest_entry_t ent;
            for (int r = 0; r < 16; r++) w[r] = msg_words[r];
            for (int r = 16; r < 64; r++)
                w[r] = mix1(w[r-2]) + w[r-7] + mix0(w[r-15]) + w[r-16];
            a = chain_words[0]; b = chain_words[1];
            c = chain_words[2]; d = chain_words[3];
            e = chain_words[4]; f = chain_words[5];
            g = chain_words[6]; h = chain_words[7];
            for (int r = 0; r < 64; r++) begin
                t1 = h + sum1(e) + ((e & f) ^ (~e & g)) + SHA_K[r] + w[r];
                t2 = sum0(a) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain_out[0] = chain_words[0] + a; chain_out[1] = chain_words[1] + b;
            chain_out[2] = chain_words[2] + c; chain_out[3] = chain_words[3] + d;
            chain_out[4] = chain_words[4] + e; chain_out[5] = chain_words[5] + f;
            chain_out[6] = chain_words[6] + g; chain_out[7] = chain_words[7] + h;
            for (int k = 0; k < 8; k++) begin
                ent.digest = chain_out[k];
                ent.index  = 3'(k);
                ent.last   = (k == 7);
                pending_digest.push_back(ent);
            end
        endfunction

        // note one accepted input word
        function void take_word(input word_t w);
            if (words_loaded < 8)
                chain_words[words_loaded] = w;
            else
                msg_words[words_loaded - 8] = {<<8{w}};
            words_loaded++;
            if (words_loaded == 24) begin
                words_loaded = 0;
                compress_block();
            end
        endfunction

        // compare one accepted output word with the oldest expectation
        function void check_word(input word_t digest, input logic [2:0] idx,
                                 input logic last);
            digest_entry_t ent;
            if (pending_digest.size() == 0) begin
                $display("%0t: unexpected output word digest %h index %0d last %0b",
                         $time, digest, idx, last);
                mismatches++;
                return;
            end
            ent = pending_digest.pop_front();
            if (digest !== ent.digest) begin
                $display("%0t: digest_word expected %h actual %h",
                         $time, ent.digest, digest);
                mismatches++;
            end
            if (idx !== ent.index) begin
                $display("%0t: word_index expected %0d actual %0d",
                         $time, ent.index, idx);
                mismatches++;
            end
            if (last !== ent.last) begin
                $display("%0t: last_word expected %0b actual %0b",
                         $time, ent.last, last);
                mismatches++;
            end
        endfunction

    endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// SHA-256 compression testbench
// Streams 24-word blocks into the block with bursty input and a stalling
// output, predicts each 8-word chain update with an independent model and
// checks every output word in order.
// ============================================================================
module tb_top;

    import sha256c_pkg::word_t;
    import sha256_digest_sb_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int RANDOM_BLOCKS = 19;
    localparam int DRAIN_CYCLES  = 200;
    localparam int HOLD_CYCLES   = 400;

    // message content styles for random blocks
    typedef enum int {
        MSG_RANDOM,
        MSG_PADDED,
        MSG_EXTREME,
        MSG_SPARSE
    } msg_style_t;

    // chaining value sources
    typedef enum int {
        CHAIN_IV256,
        CHAIN_IV224,
        CHAIN_RANDOM,
        CHAIN_FEEDBACK
    } chain_src_t;

    localparam word_t IV256 [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };
    localparam word_t IV224 [8] = '{
        32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
        32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;      // [31:0] data_word
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;      // [31:0] digest_word, [34:32] word_index
    logic        m_tlast;      // last_word

    digest_scoreboard sb = new();

    int  cycles       = 0;
    int  words_out    = 0;
    int  burst_left   = 0;

    sha256_compression dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Output monitor: check every accepted word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_word(m_tdata[31:0], m_tdata[34:32], m_tlast);
            words_out <= words_out + 1;
        end
    end

    // Receiver: cycle through stall styles, one long hold-off after the
    // second digest so the block backs up and stalls its input.
    initial
    begin
        int  rcv_cyc;
        bit  held;
        rcv_cyc  = 0;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rcv_cyc++;
            if (!held && words_out >= 16)
            begin
                // hold off for a long stretch, counted here
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                case ((rcv_cyc / 150) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) < 7);
                    2: m_tready <= ((rcv_cyc % 5) != 0);
                    default: m_tready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // Offer one word; insert a random gap whenever the current burst runs out.
    // Enter and leave at a falling edge.
    task automatic push_word(input word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge clk); while (!s_tready);
        sb.take_word(w);
        @(negedge clk);
    endtask

    task automatic push_block(input word_t chain [8], input word_t msg [16]);
        for (int i = 0; i < 8; i++) push_word(chain[i]);
        for (int i = 0; i < 16; i++) push_word(msg[i]);
    endtask

    // Build a well-formed single-block message: random bytes, 0x80 marker,
    // zeros and the big-endian bit length, loaded as little-endian words.
    task automatic make_padded(output word_t msg [16]);
        logic [7:0] bytes [64];
        int         len;
        len = $urandom_range(0, 55);
        foreach (bytes[i]) bytes[i] = 8'h00;
        for (int i = 0; i < len; i++) bytes[i] = 8'($urandom);
        bytes[len] = 8'h80;
        bytes[62]  = 8'((len * 8) >> 8);
        bytes[63]  = 8'(len * 8);
        for (int j = 0; j < 16; j++)
            msg[j] = {bytes[4*j+3], bytes[4*j+2], bytes[4*j+1], bytes[4*j]};
    endtask

    initial
    begin
        word_t      chain [8];
        word_t      msg   [16];
        msg_style_t style;
        chain_src_t src;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed block: extreme chaining words, then the padded "abc"
        // message with zero words in between and a length word at the end.
        chain = '{32'h00000000, 32'hFFFFFFFF, 32'h80000000, 32'h00000001,
                  32'hAAAAAAAA, 32'h55555555, 32'h7FFFFFFF, 32'hFFFFFFFE};
        foreach (msg[i]) msg[i] = '0;
        msg[0]  = 32'h80636261;
        msg[15] = 32'h18000000;
        push_block(chain, msg);

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            // Chaining source: an IV, random words or the last digest as the next chain.
            src = chain_src_t'($urandom_range(0, 3));
            case (src)
                CHAIN_IV256:    chain = IV256;
                CHAIN_IV224:    chain = IV224;
                CHAIN_FEEDBACK: chain = sb.chain_out;
                default:        foreach (chain[i]) chain[i] = $urandom;
            endcase

            style = msg_style_t'($urandom_range(0, 3));
            case (style)
                MSG_PADDED:  make_padded(msg);
                MSG_EXTREME:
                    foreach (msg[i])
                        case ($urandom_range(0, 2))
                            0: msg[i] = 32'h00000000;
                            1: msg[i] = 32'hFFFFFFFF;
                            default: msg[i] = $urandom;
                        endcase
                MSG_SPARSE:
                    foreach (msg[i]) msg[i] = $urandom & $urandom & $urandom;
                default:     foreach (msg[i]) msg[i] = $urandom;
            endcase

            // pause once mid-run until the block has drained completely
            if (blk == RANDOM_BLOCKS / 2)
            begin
                s_tvalid <= 1'b0;
                do @(negedge clk); while (sb.pending() != 0);
            end
            push_block(chain, msg);
        end

        // drop valid, drain, then allow the block to settle
        s_tvalid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
